// ===== sv/rmsprop_parameter_update_top_assert.svh =====
// ----------------------------------------------------------------------------
// rmsprop_parameter_update_top_assert.svh
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef RMSPROP_PARAMETER_UPDATE_TOP_ASSERT_SVH
`define RMSPROP_PARAMETER_UPDATE_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define RPU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define RPU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked in reset
`define RPU_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rpu_pkg.sv =====
// ----------------------------------------------------------------------------
// rpu_pkg
// types and constants of the rmsprop parameter update block
// ----------------------------------------------------------------------------
package rpu_pkg;

    localparam int DATA_W    = 32;
    localparam int LR_W      = 24;
    localparam int DECAY_W   = 16;
    localparam int EPS_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_W     = LR_W + DATA_W;
    localparam int S_TDATA_W = 3 * DATA_W;
    localparam int M_TDATA_W = 2 * DATA_W;

    localparam logic [LR_W-1:0]    LR_RESET    = 24'd16777;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd64880;
    localparam logic [EPS_W-1:0]   EPS_RESET   = 16'd1;
    localparam logic [DECAY_W:0]   DECAY_ONE   = 17'h10000;
    localparam logic [DATA_W-1:0]  CACHE_MAX   = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0]  PARAM_MAX   = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]  PARAM_MIN   = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEARNING_RATE = 2'd0,
        REG_DECAY_RATE    = 2'd1,
        REG_EPSILON       = 2'd2
    } reg_idx_t;

endpackage

// ===== sv/rmsprop_parameter_update_top.sv =====
// path: stages 1 to 4, square root pipeline, stage 5, divider pipeline, output register
// throughput: one transaction per cycle; the square root and divider pipelines
// retire one bit per stage, and a stall at the output holds every stage
// reset: aresetn synchronous active low, clears valid bits and restores register defaults
// ----------------------------------------------------------------------------
// rmsprop_parameter_update_top
// streaming rmsprop cache and parameter update in fixed point
// ----------------------------------------------------------------------------
module rmsprop_parameter_update_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // param_value, gradient, cache_in
    input  logic [rpu_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // updated_param, cache_out
    output logic [rpu_pkg::M_TDATA_W-1:0]    m_tdata,
    // saturated
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rpu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpu_pkg::LR_W-1:0]         cfg_data
);
    import rpu_pkg::*;

    localparam int SQ_W     = DATA_W + FRAC_BITS + (FRAC_BITS % 2);
    localparam int RB       = SQ_W / 2;
    localparam int DEN_RAW_W = RB + 1;
    localparam int LR_SHIFT = LR_W - FRAC_BITS;
    localparam int DIV_W    = DEN_RAW_W + LR_SHIFT;
    localparam int NP_W     = NUM_W + 2;

    typedef struct packed {
        logic [DATA_W-1:0] praw;
        logic              gneg;
        logic [NUM_W-1:0]  num;
        logic [DATA_W-1:0] cache;
        logic              sat;
    } sq_sb_t;

    typedef struct packed {
        logic [DATA_W-1:0] praw;
        logic              gneg;
        logic [DATA_W-1:0] cache;
        logic              sat;
    } dv_sb_t;

    localparam int SQ_SB_W = $bits(sq_sb_t);
    localparam int DV_SB_W = $bits(dv_sb_t);

    // configuration registers
    logic [LR_W-1:0]    lr_reg;
    logic [DECAY_W-1:0] decay_reg;
    logic [EPS_W-1:0]   eps_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg    <= LR_RESET;
            decay_reg <= DECAY_RESET;
            eps_reg   <= EPS_RESET;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_LEARNING_RATE: lr_reg    <= cfg_data;
                REG_DECAY_RATE:    decay_reg <= cfg_data[DECAY_W-1:0];
                REG_EPSILON:       eps_reg   <= cfg_data[EPS_W-1:0];
                default:           ;
            endcase
        end
    end

    logic en;
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // stage 1: magnitude of gradient
    logic              p1_valid_reg;
    logic [DATA_W-1:0] p1_praw_reg, p1_gmag_reg, p1_cin_reg;
    logic              p1_gneg_reg;
    logic [DATA_W-1:0] graw;
    assign graw = s_tdata[2*DATA_W-1:DATA_W];

    // stage 2: products of gradient
    logic                p2_valid_reg;
    logic [DATA_W-1:0]   p2_praw_reg, p2_cin_reg;
    logic                p2_gneg_reg;
    logic [2*DATA_W-1:0] p2_g2full_reg;
    logic [NUM_W-1:0]    p2_num_reg;

    // stage 3: weighted cache terms
    logic                       p3_valid_reg;
    logic [DATA_W-1:0]          p3_praw_reg;
    logic                       p3_gneg_reg;
    logic [NUM_W-1:0]           p3_num_reg;
    logic                       p3_over_reg;
    logic [DATA_W+DECAY_W-1:0]  p3_a_reg;
    logic [48+DECAY_W:0]        p3_b_reg;
    logic [47:0]                g2_lo;
    logic                       g2_over;

    // stage 4: new cache
    logic              p4_valid_reg;
    logic [DATA_W-1:0] p4_praw_reg;
    logic              p4_gneg_reg;
    logic [NUM_W-1:0]  p4_num_reg;
    logic [DATA_W-1:0] p4_cache_reg, cache_next;
    logic              p4_sat_reg, sat4_next;
    logic [48+DECAY_W+1:0] csum;
    logic [48+DECAY_W+1-16:0] cshift;

    always_comb begin
        g2_lo   = 48'(p2_g2full_reg >> FRAC_BITS);
        g2_over = (p2_g2full_reg >> (FRAC_BITS + 48)) != '0;
        csum    = {18'd0, p3_a_reg} + {1'b0, p3_b_reg};
        cshift  = csum[48+DECAY_W+1:16];
        if (p3_over_reg || (cshift >> DATA_W) != '0) begin
            cache_next = CACHE_MAX;
            sat4_next  = 1'b1;
        end else begin
            cache_next = cshift[DATA_W-1:0];
            sat4_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= s_tvalid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_praw_reg   <= s_tdata[DATA_W-1:0];
            p1_gneg_reg   <= graw[DATA_W-1];
            p1_gmag_reg   <= graw[DATA_W-1] ? (~graw + 1'b1) : graw;
            p1_cin_reg    <= s_tdata[3*DATA_W-1:2*DATA_W];

            p2_praw_reg   <= p1_praw_reg;
            p2_gneg_reg   <= p1_gneg_reg;
            p2_cin_reg    <= p1_cin_reg;
            p2_g2full_reg <= p1_gmag_reg * p1_gmag_reg;
            p2_num_reg    <= NUM_W'(lr_reg) * NUM_W'(p1_gmag_reg);

            p3_praw_reg   <= p2_praw_reg;
            p3_gneg_reg   <= p2_gneg_reg;
            p3_num_reg    <= p2_num_reg;
            p3_over_reg   <= g2_over;
            p3_a_reg      <= (DATA_W+DECAY_W)'(decay_reg) * (DATA_W+DECAY_W)'(p2_cin_reg);
            p3_b_reg      <= (49+DECAY_W)'(DECAY_ONE - {1'b0, decay_reg})
                             * (49+DECAY_W)'(g2_lo);

            p4_praw_reg   <= p3_praw_reg;
            p4_gneg_reg   <= p3_gneg_reg;
            p4_num_reg    <= p3_num_reg;
            p4_cache_reg  <= cache_next;
            p4_sat_reg    <= sat4_next;
        end
    end

    // square root of cache scaled by the fraction
    sq_sb_t        sq_in_sb, sq_out_sb;
    logic          sq_out_valid;
    logic [RB-1:0] sq_root;
    logic [SQ_SB_W-1:0] sq_out_bits;

    assign sq_in_sb = '{praw: p4_praw_reg, gneg: p4_gneg_reg, num: p4_num_reg,
                        cache: p4_cache_reg, sat: p4_sat_reg};
    assign sq_out_sb = sq_sb_t'(sq_out_bits);

    rpu_sqrt_pipe #(
        .IN_W (SQ_W),
        .SB_W (SQ_SB_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p4_valid_reg),
        .in_rad    (SQ_W'({p4_cache_reg, {FRAC_BITS{1'b0}}})),
        .in_sb     (sq_in_sb),
        .out_valid (sq_out_valid),
        .out_root  (sq_root),
        .out_sb    (sq_out_bits)
    );

    // stage 5: denominator
    logic                 p5_valid_reg;
    logic [NUM_W-1:0]     p5_num_reg;
    logic [DIV_W-1:0]     p5_den_reg;
    dv_sb_t               p5_sb_reg;
    logic [DEN_RAW_W-1:0] den_sum, den_fix;

    always_comb begin
        den_sum = DEN_RAW_W'(sq_root) + DEN_RAW_W'(eps_reg);
        den_fix = (den_sum == '0) ? DEN_RAW_W'(1) : den_sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p5_valid_reg <= 1'b0;
        end else if (en) begin
            p5_valid_reg <= sq_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p5_num_reg <= sq_out_sb.num;
            p5_den_reg <= DIV_W'(den_fix) << LR_SHIFT;
            p5_sb_reg  <= '{praw: sq_out_sb.praw, gneg: sq_out_sb.gneg,
                            cache: sq_out_sb.cache, sat: sq_out_sb.sat};
        end
    end

    // step magnitude
    logic             dv_out_valid;
    logic [NUM_W-1:0] dv_quo;
    logic [DV_SB_W-1:0] dv_out_bits;
    dv_sb_t           dv_out_sb;
    assign dv_out_sb = dv_sb_t'(dv_out_bits);

    rpu_div_pipe #(
        .NUM_W (NUM_W),
        .DEN_W (DIV_W),
        .SB_W  (DV_SB_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p5_valid_reg),
        .in_num    (p5_num_reg),
        .in_den    (p5_den_reg),
        .in_sb     (p5_sb_reg),
        .out_valid (dv_out_valid),
        .out_quo   (dv_quo),
        .out_sb    (dv_out_bits)
    );

    // parameter update and clipping
    logic signed [NP_W-1:0] pext, mext, np;
    logic [DATA_W-1:0]      param_next;
    logic                   clip;

    always_comb begin
        pext = NP_W'($signed(dv_out_sb.praw));
        mext = $signed({2'b00, dv_quo});
        np   = dv_out_sb.gneg ? (pext + mext) : (pext - mext);
        clip = (np[NP_W-1:DATA_W-1] != '0) && (np[NP_W-1:DATA_W-1] != '1);
        if (!clip) begin
            param_next = np[DATA_W-1:0];
        end else if (np[NP_W-1]) begin
            param_next = PARAM_MIN;
        end else begin
            param_next = PARAM_MAX;
        end
    end

    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {dv_out_sb.cache, param_next};
            m_user_reg <= dv_out_sb.sat | clip;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== sv/rpu_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// rpu_sqrt_pipe
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module rpu_sqrt_pipe #(
    parameter int IN_W = 48,
    parameter int SB_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   in_rad,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_valid,
    output logic [IN_W/2-1:0] out_root,
    output logic [SB_W-1:0]   out_sb
);
    localparam int RW = IN_W / 2;

    logic            stg_valid [RW+1];
    logic [IN_W-1:0] stg_rad   [RW+1];
    logic [RW:0]     stg_rem   [RW+1];
    logic [RW-1:0]   stg_root  [RW+1];
    logic [SB_W-1:0] stg_sb    [RW+1];

    assign stg_valid[0] = in_valid;
    assign stg_rad[0]   = in_rad;
    assign stg_rem[0]   = '0;
    assign stg_root[0]  = '0;
    assign stg_sb[0]    = in_sb;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic            valid_reg;
        logic [IN_W-1:0] rad_reg, rad_next;
        logic [RW:0]     rem_reg, rem_next;
        logic [RW-1:0]   root_reg, root_next;
        logic [SB_W-1:0] sb_reg;
        logic [RW+1:0]   cat;
        logic [RW+2:0]   diff;

        always_comb begin
            cat      = {stg_rem[k][RW-1:0], stg_rad[k][IN_W-1 -: 2]};
            diff     = {1'b0, cat} - {1'b0, stg_root[k], 2'b01};
            rad_next = stg_rad[k] << 2;
            if (!diff[RW+2]) begin
                rem_next  = diff[RW:0];
                root_next = {stg_root[k][RW-2:0], 1'b1};
            end else begin
                rem_next  = cat[RW:0];
                root_next = {stg_root[k][RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg <= 1'b0;
            end else if (en) begin
                valid_reg <= stg_valid[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg  <= rad_next;
                rem_reg  <= rem_next;
                root_reg <= root_next;
                sb_reg   <= stg_sb[k];
            end
        end

        assign stg_valid[k+1] = valid_reg;
        assign stg_rad[k+1]   = rad_reg;
        assign stg_rem[k+1]   = rem_reg;
        assign stg_root[k+1]  = root_reg;
        assign stg_sb[k+1]    = sb_reg;
    end

    assign out_valid = stg_valid[RW];
    assign out_root  = stg_root[RW];
    assign out_sb    = stg_sb[RW];

endmodule

// ===== sv/rpu_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rpu_div_pipe
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module rpu_div_pipe #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 33,
    parameter int SB_W  = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [SB_W-1:0]  in_sb,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quo,
    output logic [SB_W-1:0]  out_sb
);
    logic             stg_valid [NUM_W+1];
    logic [NUM_W-1:0] stg_nq    [NUM_W+1];
    logic [DEN_W-1:0] stg_rem   [NUM_W+1];
    logic [DEN_W-1:0] stg_den   [NUM_W+1];
    logic [SB_W-1:0]  stg_sb    [NUM_W+1];

    assign stg_valid[0] = in_valid;
    assign stg_nq[0]    = in_num;
    assign stg_rem[0]   = '0;
    assign stg_den[0]   = in_den;
    assign stg_sb[0]    = in_sb;

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic             valid_reg;
        logic [NUM_W-1:0] nq_reg, nq_next;
        logic [DEN_W-1:0] rem_reg, rem_next;
        logic [DEN_W-1:0] den_reg;
        logic [SB_W-1:0]  sb_reg;
        logic [DEN_W:0]   cat;
        logic [DEN_W+1:0] diff;

        always_comb begin
            cat  = {stg_rem[k], stg_nq[k][NUM_W-1]};
            diff = {1'b0, cat} - {2'b00, stg_den[k]};
            if (!diff[DEN_W+1]) begin
                rem_next = diff[DEN_W-1:0];
                nq_next  = {stg_nq[k][NUM_W-2:0], 1'b1};
            end else begin
                rem_next = cat[DEN_W-1:0];
                nq_next  = {stg_nq[k][NUM_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg <= 1'b0;
            end else if (en) begin
                valid_reg <= stg_valid[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg  <= nq_next;
                rem_reg <= rem_next;
                den_reg <= stg_den[k];
                sb_reg  <= stg_sb[k];
            end
        end

        assign stg_valid[k+1] = valid_reg;
        assign stg_nq[k+1]    = nq_reg;
        assign stg_rem[k+1]   = rem_reg;
        assign stg_den[k+1]   = den_reg;
        assign stg_sb[k+1]    = sb_reg;
    end

    assign out_valid = stg_valid[NUM_W];
    assign out_quo   = stg_nq[NUM_W];
    assign out_sb    = stg_sb[NUM_W];

endmodule

// ===== sv/rpu_checker.sv =====
// ----------------------------------------------------------------------------
// rpu_checker
// port-level checks of the rmsprop parameter update block
// ----------------------------------------------------------------------------
`include "rmsprop_parameter_update_top_assert.svh"

module rpu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);
    `RPU_ASSERT_RST(a_reset_idle, !aresetn, !m_tvalid, "result valid right after reset")
    `RPU_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `RPU_ASSERT_IMP(a_stall_back, m_tvalid && !m_tready, !s_tready,
        "input taken while output stalled")
    `RPU_ASSERT_IMP(a_sat_clip, m_tvalid && m_tuser,
        (m_tdata[63:32] == 32'hFFFF_FFFF) || (m_tdata[31:0] == 32'h7FFF_FFFF)
        || (m_tdata[31:0] == 32'h8000_0000), "saturation flag without clipped value")

endmodule

bind rmsprop_parameter_update_top rpu_checker u_rpu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
